// ----- rtl/fjb_pkg.sv -----
// Shared constants and types for the frame jitter buffer selector.
package fjb_pkg;

    // Fixed field widths
    localparam int NUM_W    = 31;
    localparam int LEN_W    = 16;
    localparam int STATUS_W = 2;
    localparam int HELD_W   = 5;
    localparam int DROP_W   = 16;
    localparam int CAP_W    = 5;

    // Packed widths of the stream payloads, without the handle field
    localparam int IN_FIXED_W  = NUM_W + LEN_W;
    localparam int OUT_FIXED_W = STATUS_W + 1 + 1 + NUM_W + HELD_W + DROP_W;

    // Register reset value
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd15;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_STORED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OLD    = 2'd2;

    // Playback thresholds
    localparam int START_FILL   = 3;
    localparam int FALLBACK_POS = 6;

    localparam logic [DROP_W-1:0] DROP_MAX = 16'hFFFF;

    // Classified request handed from the front to the back
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic             empty;
    } fjb_req_t;

endpackage

// ----- rtl/fjb_front.sv -----
// Front end: accepts frame requests, flags empty ones and queues them for the back end.
module fjb_front #(
    parameter int HANDLE_BITS = 16
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                s_tvalid,
    output logic                                                s_tready,
    // frame_number, payload_handle, payload_length (lowest bit up)
    input  logic [((fjb_pkg::IN_FIXED_W+HANDLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                                q_valid,
    input  logic                                                q_ready,
    output fjb_pkg::fjb_req_t                                   q_req,
    output logic [HANDLE_BITS-1:0]                              q_hnd
);
    import fjb_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    fjb_req_t                q_req_mem [QDEPTH];
    logic [HANDLE_BITS-1:0]  q_hnd_mem [QDEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg, count_next;
    logic                    push;
    logic                    pop;
    fjb_req_t                in_req;
    logic [LEN_W-1:0]        in_len;

    // Unpack and classify the incoming request
    assign in_len       = s_tdata[NUM_W+HANDLE_BITS +: LEN_W];
    assign in_req.num   = s_tdata[NUM_W-1:0];
    assign in_req.empty = (in_len == '0);

    assign s_tready = (count_reg != QCNT_W'(QDEPTH));
    assign push     = s_tvalid & s_tready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_valid & q_ready;
    assign q_req    = q_req_mem[rd_ptr_reg];
    assign q_hnd    = q_hnd_mem[rd_ptr_reg];

    // Advance queue pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store queued payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_req_mem[wr_ptr_reg] <= in_req;
            q_hnd_mem[wr_ptr_reg] <= s_tdata[NUM_W +: HANDLE_BITS];
        end
    end

endmodule

// ----- rtl/fjb_back.sv -----
// Back end: sorted frame table in a ring memory, insert/evict sequencer and playback choice.
module fjb_back #(
    parameter int TABLE_DEPTH = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic [fjb_pkg::CAP_W-1:0]                            capacity,
    input  logic                                                 q_valid,
    output logic                                                 q_ready,
    input  fjb_pkg::fjb_req_t                                    q_req,
    input  logic [HANDLE_BITS-1:0]                               q_hnd,
    output logic                                                 m_tvalid,
    input  logic                                                 m_tready,
    // status, evicted, play_valid, play_frame, play_handle, held_count,
    // dropped_total (lowest bit up)
    output logic [((fjb_pkg::OUT_FIXED_W+HANDLE_BITS+7)/8)*8-1:0] m_tdata
);
    import fjb_pkg::*;

    localparam int OUT_W  = ((OUT_FIXED_W + HANDLE_BITS + 7) / 8) * 8;
    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CNTX_W = $clog2(TABLE_DEPTH + 2);
    localparam int PW     = CNTX_W + 1;
    localparam int EW     = (CNTX_W > CAP_W) ? CNTX_W : CAP_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRCH  = 4'd1;
    localparam logic [3:0] S_INS   = 4'd2;
    localparam logic [3:0] S_SHIFT = 4'd3;
    localparam logic [3:0] S_PLACE = 4'd4;
    localparam logic [3:0] S_EVICT = 4'd5;
    localparam logic [3:0] S_RD0   = 4'd6;
    localparam logic [3:0] S_GOT0  = 4'd7;
    localparam logic [3:0] S_SEL   = 4'd8;
    localparam logic [3:0] S_SCAN0 = 4'd9;
    localparam logic [3:0] S_SCAN  = 4'd10;
    localparam logic [3:0] S_PICKD = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    // Frame table, addressed as a ring starting at base_reg
    logic [NUM_W-1:0]       mem_num [TABLE_DEPTH];
    logic [HANDLE_BITS-1:0] mem_hnd [TABLE_DEPTH];
    logic [NUM_W-1:0]       rd_num_reg;
    logic [HANDLE_BITS-1:0] rd_hnd_reg;

    logic [3:0]             state_reg, state_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [IDX_W-1:0]       base_reg, base_next;
    logic                   playing_reg, playing_next;
    logic [NUM_W-1:0]       current_reg, current_next;
    logic [DROP_W-1:0]      drop_reg, drop_next;
    logic                   out_valid_reg, out_valid_next;

    logic [NUM_W-1:0]       item_num_reg, item_num_next;
    logic [HANDLE_BITS-1:0] item_hnd_reg, item_hnd_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic                   eq_reg, eq_next;
    logic [CNTX_W-1:0]      cnt_reg, cnt_next;
    logic [NUM_W-1:0]       prev_reg, prev_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic                   res_evicted_reg, res_evicted_next;
    logic                   res_pv_reg, res_pv_next;
    logic [NUM_W-1:0]       res_pf_reg, res_pf_next;
    logic [HANDLE_BITS-1:0] res_ph_reg, res_ph_next;
    logic [OUT_W-1:0]       out_data_reg, out_data_next;

    logic [CNT_W-1:0]       rd_l;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [CNT_W-1:0]       wr_l;
    logic [IDX_W-1:0]       wr_addr;
    logic [NUM_W-1:0]       wr_num;
    logic [HANDLE_BITS-1:0] wr_hnd;
    logic [EW-1:0]          cap_w;
    logic [CNTX_W-1:0]      cap_eff;

    // Map a logical position onto the ring
    function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] b,
                                                   input logic [CNTX_W-1:0] l);
        logic [PW-1:0] s;
        s = PW'(b) + PW'(l);
        if (s >= PW'(TABLE_DEPTH))
        begin
            s = s - PW'(TABLE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    // Clamp capacity to 1..TABLE_DEPTH
    always_comb
    begin
        if (capacity == '0)
        begin
            cap_w = EW'(1);
        end
        else if (EW'(capacity) > EW'(TABLE_DEPTH))
        begin
            cap_w = EW'(TABLE_DEPTH);
        end
        else
        begin
            cap_w = EW'(capacity);
        end
    end
    assign cap_eff = CNTX_W'(cap_w);

    assign rd_addr  = ring_addr(base_reg, CNTX_W'(rd_l));
    assign wr_addr  = ring_addr(base_reg, CNTX_W'(wr_l));
    assign q_ready  = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Sequencer
    always_comb
    begin
        logic [CNT_W-1:0]  nf;
        logic [CNTX_W-1:0] start;
        logic [DROP_W:0]   dsum;

        nf    = fill_reg;
        start = '0;
        dsum  = '0;

        state_next       = state_reg;
        fill_next        = fill_reg;
        base_next        = base_reg;
        playing_next     = playing_reg;
        current_next     = current_reg;
        drop_next        = drop_reg;
        item_num_next    = item_num_reg;
        item_hnd_next    = item_hnd_reg;
        idx_next         = idx_reg;
        pos_next         = pos_reg;
        eq_next          = eq_reg;
        cnt_next         = cnt_reg;
        prev_next        = prev_reg;
        res_status_next  = res_status_reg;
        res_evicted_next = res_evicted_reg;
        res_pv_next      = res_pv_reg;
        res_pf_next      = res_pf_reg;
        res_ph_next      = res_ph_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg & ~m_tready;

        rd_l   = idx_reg;
        wr_en  = 1'b0;
        wr_l   = pos_reg;
        wr_num = item_num_reg;
        wr_hnd = item_hnd_reg;

        case (state_reg)
            S_IDLE:
            begin
                // Take the next request and clear the result
                if (q_valid)
                begin
                    item_num_next    = q_req.num;
                    item_hnd_next    = q_hnd;
                    res_status_next  = ST_STORED;
                    res_evicted_next = 1'b0;
                    res_pv_next      = 1'b0;
                    res_pf_next      = '0;
                    res_ph_next      = '0;
                    if (q_req.empty)
                    begin
                        res_status_next = ST_EMPTY;
                        state_next      = S_OUT;
                    end
                    else if (fill_reg == '0)
                    begin
                        pos_next   = '0;
                        eq_next    = 1'b0;
                        state_next = S_INS;
                    end
                    else
                    begin
                        rd_l       = '0;
                        idx_next   = '0;
                        state_next = S_SRCH;
                    end
                end
            end

            S_SRCH:
            begin
                // Find the first held frame not older than the request, or drop one older than all
                if (idx_reg == '0 && item_num_reg < rd_num_reg)
                begin
                    res_status_next = ST_OLD;
                    if (drop_reg != DROP_MAX)
                    begin
                        drop_next = drop_reg + 1'b1;
                    end
                    state_next = S_OUT;
                end
                else if (item_num_reg <= rd_num_reg)
                begin
                    pos_next   = idx_reg;
                    eq_next    = (item_num_reg == rd_num_reg);
                    state_next = S_INS;
                end
                else if (idx_reg + 1'b1 == fill_reg)
                begin
                    pos_next   = fill_reg;
                    eq_next    = 1'b0;
                    state_next = S_INS;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_l     = idx_reg + 1'b1;
                end
            end

            S_INS:
            begin
                // Replace, append, or open a gap by shifting newer entries up
                if (eq_reg)
                begin
                    wr_en      = 1'b1;
                    cnt_next   = CNTX_W'(fill_reg);
                    state_next = S_EVICT;
                end
                else if (pos_reg == fill_reg)
                begin
                    wr_en      = 1'b1;
                    cnt_next   = CNTX_W'(fill_reg) + 1'b1;
                    state_next = S_EVICT;
                end
                else
                begin
                    rd_l       = fill_reg - 1'b1;
                    idx_next   = fill_reg - 1'b1;
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                wr_en  = 1'b1;
                wr_l   = idx_reg + 1'b1;
                wr_num = rd_num_reg;
                wr_hnd = rd_hnd_reg;
                if (idx_reg == pos_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                    rd_l     = idx_reg - 1'b1;
                end
            end

            S_PLACE:
            begin
                wr_en      = 1'b1;
                cnt_next   = CNTX_W'(fill_reg) + 1'b1;
                state_next = S_EVICT;
            end

            S_EVICT:
            begin
                // Drop the oldest entries beyond capacity by moving the ring base
                if (cnt_reg > cap_eff)
                begin
                    start            = cnt_reg - cap_eff;
                    base_next        = ring_addr(base_reg, start);
                    nf               = CNT_W'(cap_eff);
                    res_evicted_next = 1'b1;
                    dsum             = {1'b0, drop_reg} + (DROP_W+1)'(start);
                    drop_next        = dsum[DROP_W] ? DROP_MAX : dsum[DROP_W-1:0];
                end
                else
                begin
                    nf = CNT_W'(cnt_reg);
                end
                fill_next = nf;
                if (nf >= CNT_W'(START_FILL))
                begin
                    if (!playing_reg)
                    begin
                        playing_next = 1'b1;
                        state_next   = S_RD0;
                    end
                    else
                    begin
                        state_next = S_SEL;
                    end
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_RD0:
            begin
                rd_l       = '0;
                state_next = S_GOT0;
            end

            S_GOT0:
            begin
                // Start playback at the oldest held frame
                current_next = rd_num_reg;
                state_next   = S_SEL;
            end

            S_SEL:
            begin
                rd_l       = fill_reg - 1'b1;
                state_next = S_SCAN0;
            end

            S_SCAN0:
            begin
                prev_next  = rd_num_reg;
                idx_next   = fill_reg - 2'd2;
                rd_l       = fill_reg - 2'd2;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                // Walk down from the newest, looking for a consecutive pair
                if (({1'b0, rd_num_reg} + 1'b1) == {1'b0, prev_reg})
                begin
                    if (rd_num_reg != current_reg)
                    begin
                        current_next = rd_num_reg;
                        res_pv_next  = 1'b1;
                        res_pf_next  = rd_num_reg;
                        res_ph_next  = rd_hnd_reg;
                    end
                    state_next = S_OUT;
                end
                else if (idx_reg == '0)
                begin
                    if (fill_reg > CNT_W'(FALLBACK_POS))
                    begin
                        rd_l = fill_reg - CNT_W'(FALLBACK_POS);
                    end
                    else
                    begin
                        rd_l = '0;
                    end
                    state_next = S_PICKD;
                end
                else
                begin
                    prev_next = rd_num_reg;
                    idx_next  = idx_reg - 1'b1;
                    rd_l      = idx_reg - 1'b1;
                end
            end

            S_PICKD:
            begin
                // Fallback choice arrives from the table
                if (rd_num_reg != current_reg)
                begin
                    current_next = rd_num_reg;
                    res_pv_next  = 1'b1;
                    res_pf_next  = rd_num_reg;
                    res_ph_next  = rd_hnd_reg;
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_W'({drop_reg, HELD_W'(fill_reg), res_ph_reg,
                                             res_pf_reg, res_pv_reg, res_evicted_reg,
                                             res_status_reg});
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            base_reg      <= '0;
            playing_reg   <= 1'b0;
            current_reg   <= '0;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            base_reg      <= base_next;
            playing_reg   <= playing_next;
            current_reg   <= current_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        item_num_reg    <= item_num_next;
        item_hnd_reg    <= item_hnd_next;
        idx_reg         <= idx_next;
        pos_reg         <= pos_next;
        eq_reg          <= eq_next;
        cnt_reg         <= cnt_next;
        prev_reg        <= prev_next;
        res_status_reg  <= res_status_next;
        res_evicted_reg <= res_evicted_next;
        res_pv_reg      <= res_pv_next;
        res_pf_reg      <= res_pf_next;
        res_ph_reg      <= res_ph_next;
        out_data_reg    <= out_data_next;
    end

    // Table memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_num[wr_addr] <= wr_num;
            mem_hnd[wr_addr] <= wr_hnd;
        end
        rd_num_reg <= mem_num[rd_addr];
        rd_hnd_reg <= mem_hnd[rd_addr];
    end

endmodule

// ----- rtl/frame_jitter_buffer_selector.sv -----
// Frame jitter buffer selector: top level with capacity register, front queue and back sequencer.
//
// Each request carries a frame number, payload handle and length, and yields exactly one
// result. The back end keeps the held frames sorted in a ring memory with a single write and
// a single registered read port; that port sets the timing. An empty frame goes straight to
// the output, and a frame dropped as too old is first compared with the oldest entry. For a
// stored frame, the search up from the oldest entry and the shift of the newer entries (one
// per cycle) together cover up to F + 1 entries with F frames held, the scan down from the
// newest for a consecutive pair covers up to the held count less one, and the step that
// starts playback adds the read of the oldest frame. A two-entry request queue in front and
// an output register behind let requests arrive and results wait while the back end works.
// No table clearing is needed after reset; only filled entries are ever read. The capacity
// register (reset 15) is written over the config channel while no request is in flight;
// the user must keep to this, as the block itself does not enforce it.
module frame_jitter_buffer_selector #(
    parameter int TABLE_DEPTH = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 cfg_valid,
    output logic                                                 cfg_ready,
    // capacity
    input  logic [fjb_pkg::CAP_W-1:0]                            cfg_data,
    input  logic                                                 s_tvalid,
    output logic                                                 s_tready,
    // frame_number, payload_handle, payload_length (lowest bit up)
    input  logic [((fjb_pkg::IN_FIXED_W+HANDLE_BITS+7)/8)*8-1:0]  s_tdata,
    output logic                                                 m_tvalid,
    input  logic                                                 m_tready,
    // status, evicted, play_valid, play_frame, play_handle, held_count,
    // dropped_total (lowest bit up)
    output logic [((fjb_pkg::OUT_FIXED_W+HANDLE_BITS+7)/8)*8-1:0] m_tdata
);
    import fjb_pkg::*;

    logic [CAP_W-1:0]       capacity_reg;
    logic                   q_valid;
    logic                   q_ready;
    fjb_req_t               q_req;
    logic [HANDLE_BITS-1:0] q_hnd;

    // Hold the capacity register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_reg <= cfg_data;
        end
    end

    fjb_front #(
        .HANDLE_BITS (HANDLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req),
        .q_hnd    (q_hnd)
    );

    fjb_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .capacity (capacity_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req),
        .q_hnd    (q_hnd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- tb/frame_jitter_buffer_selector_test.sv -----
// Self-checking testbench for the frame jitter buffer selector over its stream and config ports.
`timescale 1ns / 1ps

module frame_jitter_buffer_selector_test;

    import fjb_pkg::*;

    localparam int DEPTH       = 16;
    localparam int HANDLE_W    = 16;
    localparam int IN_W        = ((IN_FIXED_W + HANDLE_W + 7) / 8) * 8;
    localparam int OUT_W       = ((OUT_FIXED_W + HANDLE_W + 7) / 8) * 8;
    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 10;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 100;
    localparam int REPORT_LINES = 40;
    localparam logic [NUM_W-1:0] NUM_TOP = {NUM_W{1'b1}};

    // Result field offsets inside m_tdata, lowest bit up
    localparam int OFS_EVICT = STATUS_W;
    localparam int OFS_PLAY  = OFS_EVICT + 1;
    localparam int OFS_FRAME = OFS_PLAY + 1;
    localparam int OFS_HNDL  = OFS_FRAME + NUM_W;
    localparam int OFS_HELD  = OFS_HNDL + HANDLE_W;
    localparam int OFS_DROP  = OFS_HELD + HELD_W;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                evicted;
        logic                play_valid;
        logic [NUM_W-1:0]    play_frame;
        logic [HANDLE_W-1:0] play_handle;
        logic [HELD_W-1:0]   held_count;
        logic [DROP_W-1:0]   dropped_total;
    } frame_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    // frame_number, payload_handle, payload_length (lowest bit up)
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // status, evicted, play_valid, play_frame, play_handle, held_count,
    // dropped_total (lowest bit up)
    logic [OUT_W-1:0] m_tdata;

    // Shadow of the frame table and playback state
    logic [NUM_W-1:0]    held_num [0:DEPTH-1];
    logic [HANDLE_W-1:0] held_hnd [0:DEPTH-1];
    int                  held_frames = 0;
    bit                  playing = 1'b0;
    logic [NUM_W-1:0]    cur_frame = '0;
    int                  drop_total = 0;
    int                  capacity_reg = CAP_RESET;

    frame_result_t pending_results [$];

    int src_idle_pct = 29;
    int sink_idle_pct = 58;
    logic hold_pending = 1'b0;
    int hold_left = 0;

    int mismatch_count = 0;
    int results_checked = 0;
    int frames_stored = 0;
    int frames_empty = 0;
    int frames_old = 0;
    int play_commands = 0;
    int cap_writes = 0;
    logic [NUM_W-1:0] next_num = '0;

    frame_jitter_buffer_selector #(
        .TABLE_DEPTH(DEPTH),
        .HANDLE_BITS(HANDLE_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // Apply one arriving frame to the shadow table and return the result it causes
    function automatic frame_result_t advance_jitter_table(input logic [NUM_W-1:0] num,
                                                           input logic [HANDLE_W-1:0] hnd,
                                                           input logic [LEN_W-1:0] len);
        frame_result_t       r;
        logic [NUM_W-1:0]    merged_num [0:DEPTH];
        logic [HANDLE_W-1:0] merged_hnd [0:DEPTH];
        int                  cnt;
        int                  start;
        int                  cap;
        int                  k;
        int                  pick;
        bit                  placed;
        bit                  found;
        r = '0;
        r.status = ST_STORED;
        if (len == '0)
            r.status = ST_EMPTY;
        else if (held_frames > 0 && num < held_num[0])
        begin
            r.status = ST_OLD;
            if (drop_total < DROP_MAX)
                drop_total++;
        end
        else
        begin
            // merge the new frame in order; an equal number takes its place
            cnt = 0;
            placed = 1'b0;
            for (int i = 0; i < held_frames; i++)
            begin
                if (!placed && num <= held_num[i])
                begin
                    merged_num[cnt] = num;
                    merged_hnd[cnt] = hnd;
                    cnt++;
                    placed = 1'b1;
                end
                if (held_num[i] != num)
                begin
                    merged_num[cnt] = held_num[i];
                    merged_hnd[cnt] = held_hnd[i];
                    cnt++;
                end
            end
            if (!placed)
            begin
                merged_num[cnt] = num;
                merged_hnd[cnt] = hnd;
                cnt++;
            end

            // evict the oldest down to the effective capacity
            cap = (capacity_reg == 0) ? 1 : (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
            start = (cnt > cap) ? cnt - cap : 0;
            drop_total = (drop_total + start > DROP_MAX) ? DROP_MAX : drop_total + start;
            r.evicted = (start > 0);
            held_frames = cnt - start;
            for (int i = 0; i < held_frames; i++)
            begin
                held_num[i] = merged_num[start + i];
                held_hnd[i] = merged_hnd[start + i];
            end

            if (!playing && held_frames >= START_FILL)
            begin
                playing = 1'b1;
                cur_frame = held_num[0];
            end

            // pick newest frame with a successor, else the fallback position
            if (playing && held_frames >= START_FILL)
            begin
                found = 1'b0;
                k = held_frames - 1;
                while (k > 0 && !found)
                begin
                    k--;
                    if ({1'b0, held_num[k + 1]} == {1'b0, held_num[k]} + 32'd1)
                        found = 1'b1;
                end
                if (found)
                    pick = k;
                else if (held_frames > FALLBACK_POS)
                    pick = held_frames - FALLBACK_POS;
                else
                    pick = 0;
                if (held_num[pick] != cur_frame)
                begin
                    cur_frame = held_num[pick];
                    r.play_valid = 1'b1;
                    r.play_frame = held_num[pick];
                    r.play_handle = held_hnd[pick];
                end
            end
        end
        r.held_count = HELD_W'(held_frames);
        r.dropped_total = DROP_W'(drop_total);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES)
            $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
                     results_checked, what, got, want);
    endtask

    // Offer one frame request and record its expected result on acceptance
    task automatic send_frame(input logic [NUM_W-1:0] num, input logic [HANDLE_W-1:0] hnd,
                              input logic [LEN_W-1:0] len);
        frame_result_t r;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_W'({len, hnd, num});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = advance_jitter_table(num, hnd, len);
        pending_results.push_back(r);
        case (r.status)
            ST_STORED: frames_stored++;
            ST_EMPTY:  frames_empty++;
            default:   frames_old++;
        endcase
        if (r.play_valid)
            play_commands++;
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        capacity_reg = value;
        cap_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Start playback, consecutive pick, duplicate replace, empty and extreme fields
    task automatic table_fill_test();
        send_frame(31'd10, 16'h5a5a, 16'h0000);
        send_frame(31'd0, 16'h0000, 16'hffff);
        send_frame(31'd4, 16'hffff, 16'h0001);
        send_frame(31'd2, 16'h1234, 16'h0100);
        send_frame(31'd3, 16'h4321, 16'h0200);
        send_frame(31'd3, 16'hbeef, 16'h0200);
        send_frame(31'd8, 16'h0008, 16'h7fff);
        send_frame(31'd12, 16'h000c, 16'h8000);
        send_frame(31'd14, 16'h000e, 16'h0003);
        send_frame(31'd20, 16'h0014, 16'h0004);
    endtask

    // Lowered capacity, too-old frame, capacity below and above range
    task automatic capacity_change_test();
        write_capacity(5'd2);
        send_frame(31'd21, 16'h0015, 16'h0010);
        send_frame(31'd1, 16'h0001, 16'h0010);
        send_frame(31'd21, 16'h0115, 16'h0000);
        write_capacity(5'd0);
        send_frame(31'd30, 16'h001e, 16'h0020);
        write_capacity(5'd31);
        send_frame(31'd31, 16'h001f, 16'h0020);
        send_frame(31'd33, 16'h0021, 16'h0020);
        send_frame(31'd35, 16'h0023, 16'h0020);
        write_capacity(5'd16);
        send_frame(31'd32, 16'h0020, 16'h0020);
        next_num = 31'd40;
    endtask

    // Mostly an in-order stream with gaps, late, repeated, early and stale frames
    task automatic send_stream_item();
        logic [NUM_W-1:0]    num;
        logic [HANDLE_W-1:0] hnd;
        logic [LEN_W-1:0]    len;
        int                  pick;
        int                  back;
        pick = $urandom_range(99);
        hnd = HANDLE_W'($urandom);
        len = ($urandom_range(9) == 0) ? 16'hffff : LEN_W'($urandom_range(1, 65535));
        if (pick < 60)
        begin
            num = next_num;
            next_num = next_num + NUM_W'(($urandom_range(4) == 0) ? $urandom_range(2, 4) : 1);
        end
        else if (pick < 75)
        begin
            back = $urandom_range(1, 8);
            num = (next_num > back) ? next_num - NUM_W'(back) : '0;
        end
        else if (pick < 83)
            num = next_num - 1'b1;
        else if (pick < 88)
            num = next_num + NUM_W'($urandom_range(1, 5));
        else if (pick < 93)
        begin
            num = next_num;
            len = '0;
        end
        else if (pick < 99)
        begin
            back = $urandom_range(20, 1000);
            num = (next_num > back) ? next_num - NUM_W'(back) : '0;
        end
        else
        begin
            // resync jump far ahead
            next_num = next_num + NUM_W'($urandom_range(1, 65536));
            num = next_num;
        end
        send_frame(num, hnd, len);
    endtask

    task automatic random_phase(input int src_pct, input int sink_pct, input int frames,
                                input int jump_lo, input int jump_hi);
        int sent;
        logic [CAP_W-1:0] cap;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        next_num = next_num + NUM_W'($urandom_range(jump_lo, jump_hi));
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            case (chunk)
                0:       cap = 5'd16;
                1:       cap = CAP_W'($urandom_range(7, 15));
                2:       cap = CAP_W'($urandom_range(3, 6));
                default: cap = CAP_W'($urandom_range(0, 31));
            endcase
            write_capacity(cap);
            sent = 0;
            while (sent < frames / 4)
            begin
                send_stream_item();
                if (pending_results[$].status != ST_EMPTY)
                    sent++;
            end
        end
    endtask

    // Hold the receiver off while the sender keeps offering, so the input stalls
    task automatic backpressure_test();
        write_capacity(5'd12);
        src_idle_pct = 0;
        hold_pending <= 1'b1;
        for (int i = 0; i < 12; i++)
            send_stream_item();
    endtask

    // Frames at the top of the number range; the highest has no successor
    task automatic number_top_test();
        write_capacity(5'd16);
        send_frame(NUM_TOP - 31'd6, 16'h0101, 16'hffff);
        send_frame(NUM_TOP, 16'h0202, 16'h0040);
        send_frame(NUM_TOP - 31'd4, 16'h0303, 16'h0040);
        send_frame(NUM_TOP - 31'd1, 16'h0404, 16'h0040);
        send_frame(NUM_TOP, 16'hffff, 16'h0040);
        send_frame(NUM_TOP - 31'd2, 16'h0505, 16'h0040);
    endtask

    // Collapse the table to a single frame in one step
    task automatic eviction_burst_test();
        write_capacity(5'd1);
        send_frame(NUM_TOP, 16'h0f0f, 16'h0001);
    endtask

    // Drive the receiver ready: random idling or a long hold when asked
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_pending)
        begin
            hold_pending <= 1'b0;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request waiting", 32'(m_tdata), 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[0 +: STATUS_W] !== want.status)
                    report_mismatch("status", 32'(m_tdata[0 +: STATUS_W]), 32'(want.status));
                if (m_tdata[OFS_EVICT] !== want.evicted)
                    report_mismatch("evicted", 32'(m_tdata[OFS_EVICT]), 32'(want.evicted));
                if (m_tdata[OFS_PLAY] !== want.play_valid)
                    report_mismatch("play_valid", 32'(m_tdata[OFS_PLAY]),
                                    32'(want.play_valid));
                if (m_tdata[OFS_FRAME +: NUM_W] !== want.play_frame)
                    report_mismatch("play_frame", 32'(m_tdata[OFS_FRAME +: NUM_W]),
                                    32'(want.play_frame));
                if (m_tdata[OFS_HNDL +: HANDLE_W] !== want.play_handle)
                    report_mismatch("play_handle", 32'(m_tdata[OFS_HNDL +: HANDLE_W]),
                                    32'(want.play_handle));
                if (m_tdata[OFS_HELD +: HELD_W] !== want.held_count)
                    report_mismatch("held_count", 32'(m_tdata[OFS_HELD +: HELD_W]),
                                    32'(want.held_count));
                if (m_tdata[OFS_DROP +: DROP_W] !== want.dropped_total)
                    report_mismatch("dropped_total", 32'(m_tdata[OFS_DROP +: DROP_W]),
                                    32'(want.dropped_total));
            end
            results_checked++;
        end
    end

    // End the run when no request moves for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no request moved for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        table_fill_test();
        capacity_change_test();
        random_phase(29, 58, 260, 100, 1000);
        backpressure_test();
        random_phase(58, 29, 260, 1 << 20, 1 << 28);
        random_phase(0, 0, 260, 1 << 28, 1 << 29);
        number_top_test();
        eviction_burst_test();

        // Let the last results come back and the block settle
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d stored, %0d empty and %0d too-old frames; %0d results checked",
                 frames_stored, frames_empty, frames_old, results_checked);
        $display("%0d play commands, %0d capacity writes, long receiver hold, drop count %0d",
                 play_commands, cap_writes, drop_total);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
